// File: design/avcc_to_annexb_parameter_sets_macros.svh
// ----------------------------------------------------------------------------
// avcC to Annex B converter assertion macros
// Shared property shorthands for the port checker.
// ----------------------------------------------------------------------------
`ifndef AVCC_TO_ANNEXB_PARAMETER_SETS_MACROS_SVH
`define AVCC_TO_ANNEXB_PARAMETER_SETS_MACROS_SVH

// same-cycle implication, gated by reset
`define A2B_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("a2b check failed: lbl");

// next-cycle implication, gated by reset
`define A2B_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("a2b check failed: lbl");

`endif

// File: design/a2b_pkg.sv
// ----------------------------------------------------------------------------
// a2b_pkg
// Shared types and constants of the avcC to Annex B converter.
// ----------------------------------------------------------------------------
package a2b_pkg;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_TRUNC    = 2'd1;
   localparam logic [1:0] ST_NOT_AVCC = 2'd2;

   localparam logic [7:0] START_ZERO  = 8'h00;
   localparam logic [7:0] START_LAST  = 8'h01;
   localparam logic [2:0] START_LEN   = 3'd4;
   localparam logic [2:0] DEF_LEN_SIZE = 3'd4;

   typedef struct packed {
      logic       has_start;
      logic       has_byte;
      logic       has_status;
      logic [7:0] data;
      logic [1:0] status;
      logic [2:0] length_size;
      logic       is_nal;
   } cmd_type;

endpackage

// File: design/a2b_front.sv
// ----------------------------------------------------------------------------
// a2b_front
// Record parser: walks the avcC header and set lists one byte a cycle
// while the queue is not full, and issues emit commands.
// ----------------------------------------------------------------------------
module a2b_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // in_byte[7:0]
   input  logic               req_tlast,
   input  logic               queue_full,
   output logic               push,
   output a2b_pkg::cmd_type   push_cmd
);
   import a2b_pkg::*;

   typedef enum logic [3:0] {
      PH_HEADER, PH_SPS_LH, PH_SPS_LL, PH_SPS_PAY, PH_PPS_CNT,
      PH_PPS_LH, PH_PPS_LL, PH_PPS_PAY, PH_DONE, PH_NOT_AVCC
   } phase_type;

   phase_type   phase_ff,  phase_in;
   logic [2:0]  hdr_idx_ff, hdr_idx_in;
   logic [7:0]  sets_ff,   sets_in;
   logic [15:0] bytes_ff,  bytes_in;
   logic [7:0]  len_hi_ff, len_hi_in;
   logic [2:0]  size_ff,   size_in;
   logic        avcc_ff,   avcc_in;
   logic        accept;
   logic        set_end;
   logic [15:0] new_len;
   cmd_type     cmd;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign set_end    = (sets_ff == 8'd1);
   assign new_len    = {len_hi_ff, req_tdata};

   always_comb begin
      phase_in   = phase_ff;
      hdr_idx_in = hdr_idx_ff;
      sets_in    = sets_ff;
      bytes_in   = bytes_ff;
      len_hi_in  = len_hi_ff;
      size_in    = size_ff;
      avcc_in    = avcc_ff;
      cmd        = '0;
      unique case (phase_ff)
         PH_HEADER: begin
            if (hdr_idx_ff == 3'd0 && req_tdata != 8'd1) begin
               avcc_in  = 1'b0;
               size_in  = DEF_LEN_SIZE;
               phase_in = PH_NOT_AVCC;
            end else begin
               if (hdr_idx_ff == 3'd0) avcc_in = 1'b1;
               if (hdr_idx_ff == 3'd4) size_in = {1'b0, req_tdata[1:0]} + 3'd1;
               if (hdr_idx_ff >= 3'd5) begin
                  sets_in  = {3'b000, req_tdata[4:0]};
                  phase_in = (req_tdata[4:0] != 5'd0) ? PH_SPS_LH : PH_PPS_CNT;
               end else begin
                  hdr_idx_in = hdr_idx_ff + 3'd1;
               end
            end
         end
         PH_SPS_LH: begin
            len_hi_in = req_tdata;
            phase_in  = PH_SPS_LL;
         end
         PH_PPS_LH: begin
            len_hi_in = req_tdata;
            phase_in  = PH_PPS_LL;
         end
         PH_SPS_LL, PH_PPS_LL: begin
            bytes_in      = new_len;
            cmd.has_start = 1'b1;
            if (new_len == 16'd0) begin
               sets_in = sets_ff - 8'd1;
               if (phase_ff == PH_SPS_LL)
                  phase_in = set_end ? PH_PPS_CNT : PH_SPS_LH;
               else
                  phase_in = set_end ? PH_DONE : PH_PPS_LH;
            end else begin
               phase_in = (phase_ff == PH_SPS_LL) ? PH_SPS_PAY : PH_PPS_PAY;
            end
         end
         PH_SPS_PAY, PH_PPS_PAY: begin
            cmd.has_byte = 1'b1;
            cmd.data     = req_tdata;
            bytes_in     = bytes_ff - 16'd1;
            if (bytes_ff == 16'd1) begin
               sets_in = sets_ff - 8'd1;
               if (phase_ff == PH_SPS_PAY)
                  phase_in = set_end ? PH_PPS_CNT : PH_SPS_LH;
               else
                  phase_in = set_end ? PH_DONE : PH_PPS_LH;
            end
         end
         PH_PPS_CNT: begin
            sets_in  = req_tdata;
            phase_in = (req_tdata != 8'd0) ? PH_PPS_LH : PH_DONE;
         end
         PH_DONE, PH_NOT_AVCC: begin
         end
      endcase
      cmd.length_size = size_in;
      cmd.is_nal      = avcc_in;
      if (req_tlast) begin
         cmd.has_status = 1'b1;
         priority if (phase_in == PH_NOT_AVCC) cmd.status = ST_NOT_AVCC;
         else if (phase_in == PH_DONE)         cmd.status = ST_OK;
         else                                  cmd.status = ST_TRUNC;
         phase_in   = PH_HEADER;
         hdr_idx_in = 3'd0;
         sets_in    = 8'd0;
         bytes_in   = 16'd0;
         len_hi_in  = 8'd0;
         size_in    = DEF_LEN_SIZE;
         avcc_in    = 1'b0;
      end
   end

   assign push     = accept && (cmd.has_start || cmd.has_byte || cmd.has_status);
   assign push_cmd = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         hdr_idx_ff <= 3'd0;
         sets_ff    <= 8'd0;
         bytes_ff   <= 16'd0;
         len_hi_ff  <= 8'd0;
         size_ff    <= DEF_LEN_SIZE;
         avcc_ff    <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         hdr_idx_ff <= hdr_idx_in;
         sets_ff    <= sets_in;
         bytes_ff   <= bytes_in;
         len_hi_ff  <= len_hi_in;
         size_ff    <= size_in;
         avcc_ff    <= avcc_in;
      end
   end

endmodule

// File: design/a2b_queue.sv
// ----------------------------------------------------------------------------
// a2b_queue
// Small command FIFO between the parser and the emitter.
// ----------------------------------------------------------------------------
module a2b_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  a2b_pkg::cmd_type   push_cmd,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output a2b_pkg::cmd_type   head
);
   import a2b_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type         mem [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff,  count_in;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push)
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      if (pop)
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      if (push && !pop)
         count_in = count_ff + CW'(1);
      else if (pop && !push)
         count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: design/a2b_back.sv
// ----------------------------------------------------------------------------
// a2b_back
// Emitter: expands each command into start code, payload and status words
// behind a registered output stage.
// ----------------------------------------------------------------------------
module a2b_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  a2b_pkg::cmd_type   cmd,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [15:0]        rsp_tdata,   // out_byte[7:0], status[9:8],
                                           // length_size[12:10], is_nal[13]
   output logic               rsp_tuser,   // is_status
   output logic               rsp_tlast
);
   import a2b_pkg::*;

   logic [2:0]  sub_ff,    sub_in;
   logic        valid_ff,  valid_in;
   logic [7:0]  byte_ff,   byte_in;
   logic [1:0]  stat_ff,   stat_in;
   logic [2:0]  lsize_ff,  lsize_in;
   logic        nal_ff,    nal_in;
   logic        is_st_ff,  is_st_in;
   logic [2:0]  n_items;
   logic        last_item;
   logic        load;

   assign n_items   = (cmd.has_start ? START_LEN : 3'd0)
                    + {2'b00, cmd.has_byte} + {2'b00, cmd.has_status};
   assign last_item = (sub_ff == n_items - 3'd1);
   assign load      = cmd_valid && (!valid_ff || rsp_tready);
   assign pop       = load && last_item;

   always_comb begin
      sub_in   = sub_ff;
      valid_in = valid_ff && !rsp_tready;
      byte_in  = byte_ff;
      stat_in  = stat_ff;
      lsize_in = lsize_ff;
      nal_in   = nal_ff;
      is_st_in = is_st_ff;
      if (load) begin
         valid_in = 1'b1;
         sub_in   = last_item ? 3'd0 : sub_ff + 3'd1;
         lsize_in = cmd.length_size;
         nal_in   = cmd.is_nal;
         is_st_in = cmd.has_status && last_item;
         stat_in  = (cmd.has_status && last_item) ? cmd.status : ST_OK;
         priority if (cmd.has_start && !sub_ff[2])
            byte_in = (sub_ff == 3'd3) ? START_LAST : START_ZERO;
         else if (cmd.has_byte && !(cmd.has_status && last_item))
            byte_in = cmd.data;
         else
            byte_in = 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         sub_ff   <= sub_in;
         valid_ff <= valid_in;
      end
      byte_ff  <= byte_in;
      stat_ff  <= stat_in;
      lsize_ff <= lsize_in;
      nal_ff   <= nal_in;
      is_st_ff <= is_st_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {2'b00, nal_ff, lsize_ff, stat_ff, byte_ff};
   assign rsp_tuser  = is_st_ff;
   assign rsp_tlast  = is_st_ff;

endmodule

// File: design/avcc_to_annexb_parameter_sets.sv
// Result words pass from the command queue through a registered output stage.
// Throughput: one input byte per cycle while req_tready is high; payload bytes
// stream at one word per cycle while rsp_tready is high. A length-low byte expands
// to four start code words, so the output word rate sets the pace there and the
// command queue backs up into req_tready. Reset (synchronous, active high) returns
// the parser to the header phase and empties the queue and output stage.
// ----------------------------------------------------------------------------
// avcc_to_annexb_parameter_sets
// Converts an avcC configuration record into Annex B parameter sets with a
// trailing status word.
// ----------------------------------------------------------------------------
module avcc_to_annexb_parameter_sets #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // in_byte[7:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // out_byte[7:0], status[9:8],
                                     // length_size[12:10], is_nal[13]
   output logic        rsp_tuser,    // is_status
   output logic        rsp_tlast
);
   import a2b_pkg::*;

   logic    push;
   logic    pop;
   logic    queue_full;
   logic    queue_valid;
   cmd_type push_cmd;
   cmd_type head_cmd;

   a2b_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   a2b_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_valid),
      .head      (head_cmd)
   );

   a2b_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (queue_valid),
      .cmd        (head_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: design/a2b_checker.sv
// ----------------------------------------------------------------------------
// a2b_checker
// Port-level checks on the result stream of the converter.
// ----------------------------------------------------------------------------
`include "avcc_to_annexb_parameter_sets_macros.svh"

module a2b_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,   // out_byte[7:0], status[9:8],
                                   // length_size[12:10], is_nal[13]
   input logic        rsp_tuser,   // is_status
   input logic        rsp_tlast
);
   import a2b_pkg::*;

   `A2B_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `A2B_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_tvalid)
   `A2B_ASSERT_IMP(a_status_last, clock, reset, rsp_tvalid, rsp_tuser == rsp_tlast)
   `A2B_ASSERT_IMP(a_byte_status, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata[9:8] == ST_OK)

endmodule

bind avcc_to_annexb_parameter_sets a2b_checker u_a2b_checker (.*);
